// ===== rtl/irp_pkg.sv =====
// Shared types and constants for the interval row packer.
// No dependencies; used by interval_row_packer and irp_store.
`timescale 1ns / 1ps

package irp_pkg;

  localparam int DEFAULT_LEVELS = 64;

  localparam logic [31:0] START_RESET = 32'd1215752191;
  localparam logic [31:0] END_RESET   = 32'd0;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_JOIN_LEFT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVELS_IN_USE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TLEN_MODE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_SIZE   = 3'd4;

  localparam logic [6:0] LEVELS_IN_USE_RESET = 7'd64;

  // stored extent of one level
  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] end_pos;
  } extent_t;

endpackage

// ===== rtl/interval_row_packer.sv =====
// Top level of the interval row packer: sequencer, config registers, shared compare.
// Depends on irp_pkg and irp_store.
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// --------  -----------------------  ---------------------------------------
// request   start & !busy            span_start, span_end, template_len
// result    done (one-cycle strobe)  row, row_valid, fit_found
// config    cfg_wr_en                cfg_index, cfg_data
//
// A request is scanned level by level from 0 up to limit, where
// limit = min(levels_in_use, LEVELS); a fitting level goes through S_UPDATE,
// then S_FIN strobes the result (S_FIN directly if no level fits or limit is 0).
// The pace is set by the single read port of the level memory: one level is
// tested a cycle. A new request may be accepted in the cycle its predecessor's
// result is shown. After reset the block is busy while it sweeps the level
// memory to its reset extents; config writes are taken meanwhile.
// The receiver cannot stall: done is high for one cycle; the payload then holds.

module interval_row_packer #(
  parameter int LEVELS = irp_pkg::DEFAULT_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  // request
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     span_start,
  input  logic [31:0]                     span_end,
  input  logic [30:0]                     template_len,
  // result
  output logic                            done,
  output logic [30:0]                     row,
  output logic                            row_valid,
  output logic                            fit_found,
  // config
  input  logic                            cfg_wr_en,
  input  logic [irp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [irp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;  // memory index
  localparam int LW = $clog2(LEVELS + 1);                 // holds LEVELS itself
  localparam int CW = (LW > 7) ? LW : 7;                  // level count compare
  localparam int RW = (AW > 6) ? AW : 6;                  // row subtraction

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FIN
  } state_t;

  // config registers
  logic        join_left;
  logic [5:0]  scroll_offset;
  logic [6:0]  levels_in_use;
  logic        tlen_mode;
  logic [30:0] region_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      join_left     <= 1'b0;
      scroll_offset <= '0;
      levels_in_use <= irp_pkg::LEVELS_IN_USE_RESET;
      tlen_mode     <= 1'b0;
      region_size   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        irp_pkg::REG_JOIN_LEFT:     join_left     <= cfg_data[0];
        irp_pkg::REG_SCROLL_OFFSET: scroll_offset <= cfg_data[5:0];
        irp_pkg::REG_LEVELS_IN_USE: levels_in_use <= cfg_data[6:0];
        irp_pkg::REG_TLEN_MODE:     tlen_mode     <= cfg_data[0];
        irp_pkg::REG_REGION_SIZE:   region_size   <= cfg_data[30:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  state_t      state;
  logic [AW-1:0] lvl;      // level under test; sweep address in S_CLEAR
  logic [CW-1:0] limit;
  logic [31:0] req_start;
  logic [31:0] req_end;
  logic [30:0] req_tlen;
  logic        found_q;
  logic        valid_q;
  logic [30:0] row_q;

  // level memory
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  irp_pkg::extent_t mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  irp_pkg::extent_t rd;

  irp_store #(
    .LEVELS (LEVELS),
    .AW     (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  // shared unsigned compare: lt = cmp_a < cmp_b
  //   scan:   fit test of the level just read
  //   update: whether the stored extent grows on its other side
  //   fin:    template length against region size
  logic [31:0] cmp_a;
  logic [31:0] cmp_b;
  logic        lt;

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_SCAN: begin
        cmp_a = join_left ? req_end : rd.end_pos;
        cmp_b = join_left ? rd.start_pos : req_start;
      end
      S_UPDATE: begin
        cmp_a = join_left ? rd.end_pos : req_start;
        cmp_b = join_left ? req_end : rd.start_pos;
      end
      S_FIN: begin
        cmp_a = {1'b0, req_tlen};
        cmp_b = {1'b0, region_size};
      end
      default: ;
    endcase
  end

  assign lt = cmp_a < cmp_b;

  // level count searched, saturated to the store depth
  logic [CW-1:0] limit_next;
  logic [CW-1:0] lvl_inc;
  logic          last_level;

  assign limit_next = (CW'(levels_in_use) > CW'(LEVELS)) ? CW'(LEVELS) : CW'(levels_in_use);
  assign lvl_inc    = CW'(lvl) + CW'(1);
  assign last_level = lvl_inc >= limit;

  // row from level, valid when at or above the scroll offset
  logic [RW-1:0] lvl_ext;
  logic [RW-1:0] scroll_ext;
  logic [RW-1:0] row_diff;

  assign lvl_ext    = RW'(lvl);
  assign scroll_ext = RW'(scroll_offset);
  assign row_diff   = lvl_ext - scroll_ext;

  // memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lvl;
    mem_wdata = '{start_pos: irp_pkg::START_RESET, end_pos: irp_pkg::END_RESET};
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re = start && (limit_next != '0);
      end
      S_SCAN: begin
        mem_re    = !lt && !last_level;
        mem_raddr = AW'(lvl_inc);
      end
      S_UPDATE: begin
        mem_we = 1'b1;
        if (join_left) begin
          mem_wdata.start_pos = req_start;
          mem_wdata.end_pos   = lt ? req_end : rd.end_pos;
        end else begin
          mem_wdata.end_pos   = req_end;
          mem_wdata.start_pos = lt ? req_start : rd.start_pos;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      lvl       <= '0;
      done      <= 1'b0;
      found_q   <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (lvl == AW'(LEVELS - 1)) begin
            lvl   <= '0;
            state <= S_IDLE;
          end else begin
            lvl <= lvl + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            req_start <= span_start;
            req_end   <= span_end;
            req_tlen  <= template_len;
            limit     <= limit_next;
            lvl       <= '0;
            found_q   <= 1'b0;
            valid_q   <= 1'b0;
            row_q     <= '0;
            state     <= (limit_next == '0) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (lt) begin
            state <= S_UPDATE;
          end else if (last_level) begin
            state <= S_FIN;
          end else begin
            lvl <= AW'(lvl_inc);
          end
        end
        S_UPDATE: begin
          found_q <= 1'b1;
          if (lvl_ext >= scroll_ext) begin
            valid_q <= 1'b1;
            row_q   <= 31'(row_diff);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          done      <= 1'b1;
          fit_found <= found_q;
          if (tlen_mode) begin
            row       <= lt ? req_tlen : region_size;
            row_valid <= 1'b1;
          end else begin
            row       <= row_q;
            row_valid <= valid_q;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/irp_store.sv =====
// Level extent memory: one write port, one registered read port.
// Depends on irp_pkg (extent_t).
`timescale 1ns / 1ps

module irp_store #(
  parameter int LEVELS = irp_pkg::DEFAULT_LEVELS,
  parameter int AW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  irp_pkg::extent_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output irp_pkg::extent_t rdata
);

  irp_pkg::extent_t mem [LEVELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/irp_checks.sv =====
// Port-level checks for interval_row_packer, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module irp_checks (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [30:0] row,
  input logic        row_valid,
  input logic        fit_found
);

  // reset starts the memory sweep
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make block busy");

  // a result is shown only once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // one strobe per request; the next can come only after a new search
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");

  // an unplaced read reports row zero
  a_unplaced_row: assert property (@(posedge clk) disable iff (rst)
    (done && !row_valid) |-> (row == 31'd0 && (fit_found || !fit_found)))
    else $error("unplaced read with nonzero row");

endmodule

bind interval_row_packer irp_checks u_irp_checks (.*);
